>>> design/cspm_pkg.sv
// ----------------------------------------------------------------------------
// cspm_pkg: shared sizes, codes and types of the 3x3 convolution block
// Holds the image and kernel geometry, the derived memory address widths,
// the request kind codes and the control word that rides along the MAC path.
// ----------------------------------------------------------------------------
package cspm_pkg;

  // Geometry and data widths
  localparam int IN_CH     = 4;
  localparam int OUT_CH    = 8;
  localparam int IMG_H     = 32;
  localparam int IMG_W     = 32;
  localparam int DATA_BITS = 16;
  localparam int ACC_BITS  = 40;

  localparam int TAPS       = 9;
  localparam int PLANE      = IMG_H * IMG_W;
  localparam int FMAP_DEPTH = IN_CH * PLANE;
  localparam int KERN_DEPTH = OUT_CH * IN_CH * TAPS;
  localparam int FMAP_AW    = $clog2(FMAP_DEPTH);
  localparam int KERN_AW    = $clog2(KERN_DEPTH);
  localparam int CH_W       = (IN_CH > 1) ? $clog2(IN_CH) : 1;
  localparam int PROD_BITS  = 2 * DATA_BITS;

  // Fixed request field widths
  localparam int KIND_W = 2;
  localparam int OC_W   = 3;
  localparam int IC_W   = 2;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 5;
  localparam int TAP_W  = 2;
  localparam int VAL_W  = 16;

  // Last kernel row / column index
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(2);

  typedef enum logic [KIND_W-1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_PIXEL  = 2'd2
  } kind_e;

  // Control word that follows one tap through read, multiply and accumulate
  typedef struct packed {
    logic valid;
    logic pad;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

>>> design/cspm_ram.sv
// ----------------------------------------------------------------------------
// cspm_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cspm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/cspm_seq.sv
// ----------------------------------------------------------------------------
// cspm_seq: tap sequencer for one output pixel
// Walks input channel, kernel row and kernel column, issues one memory read
// per tap and flags taps that fall in the zero padding.
// ----------------------------------------------------------------------------
module cspm_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           go_i,
  input  logic [cspm_pkg::ROW_W-1:0]     row_i,
  input  logic [cspm_pkg::COL_W-1:0]     col_i,
  input  logic [cspm_pkg::KERN_AW-1:0]   kbase_i,
  input  logic                           done_i,
  output logic                           busy_o,
  output logic [cspm_pkg::FMAP_AW-1:0]   faddr_o,
  output logic [cspm_pkg::KERN_AW-1:0]   kaddr_o,
  output cspm_pkg::mac_ctrl_t            ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e                         state_q, state_d;
  logic [cspm_pkg::CH_W-1:0]      ch_q, ch_d;
  logic [cspm_pkg::TAP_W-1:0]     i_q, i_d;
  logic [cspm_pkg::TAP_W-1:0]     j_q, j_d;
  logic [cspm_pkg::ROW_W-1:0]     row_q, row_d;
  logic [cspm_pkg::COL_W-1:0]     col_q, col_d;
  logic [cspm_pkg::KERN_AW-1:0]   kaddr_q, kaddr_d;

  logic [cspm_pkg::ROW_W:0]       pr;
  logic [cspm_pkg::COL_W:0]       pc;
  logic [cspm_pkg::ROW_W:0]       pr_m1;
  logic [cspm_pkg::COL_W:0]       pc_m1;
  logic                           row_ok, col_ok;
  logic                           first_tap, last_tap;

  // Window position is (row + i - 1, col + j - 1); keep it unsigned
  assign pr     = {1'b0, row_q} + (cspm_pkg::ROW_W + 1)'(i_q);
  assign pc     = {1'b0, col_q} + (cspm_pkg::COL_W + 1)'(j_q);
  assign pr_m1  = pr - 1'b1;
  assign pc_m1  = pc - 1'b1;
  assign row_ok = (pr != '0) && (32'(pr_m1) < cspm_pkg::IMG_H);
  assign col_ok = (pc != '0) && (32'(pc_m1) < cspm_pkg::IMG_W);

  assign first_tap = (ch_q == '0) && (i_q == '0) && (j_q == '0);
  assign last_tap  = (32'(ch_q) == cspm_pkg::IN_CH - 1) && (i_q == cspm_pkg::TAP_LAST)
                     && (j_q == cspm_pkg::TAP_LAST);

  assign faddr_o = cspm_pkg::FMAP_AW'(32'(ch_q) * cspm_pkg::PLANE
                                      + 32'(pr_m1) * cspm_pkg::IMG_W + 32'(pc_m1));
  assign kaddr_o = kaddr_q;

  always_comb begin
    ctrl_o.valid = (state_q == ST_RUN);
    ctrl_o.pad   = !(row_ok && col_ok);
    ctrl_o.first = first_tap;
    ctrl_o.last  = last_tap;
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    i_d     = i_q;
    j_d     = j_q;
    row_d   = row_q;
    col_d   = col_q;
    kaddr_d = kaddr_q;
    case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          state_d = ST_RUN;
          ch_d    = '0;
          i_d     = '0;
          j_d     = '0;
          row_d   = row_i;
          col_d   = col_i;
          kaddr_d = kbase_i;
        end
      end
      ST_RUN: begin
        // Kernel entries of one output channel are contiguous in tap order
        kaddr_d = kaddr_q + 1'b1;
        if (last_tap) begin
          state_d = ST_DRAIN;
        end else if (j_q == cspm_pkg::TAP_LAST) begin
          j_d = '0;
          if (i_q == cspm_pkg::TAP_LAST) begin
            i_d  = '0;
            ch_d = ch_q + 1'b1;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (done_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      row_q   <= '0;
      col_q   <= '0;
      kaddr_q <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      i_q     <= i_d;
      j_q     <= j_d;
      row_q   <= row_d;
      col_q   <= col_d;
      kaddr_q <= kaddr_d;
    end
  end

endmodule

>>> design/cspm_mac.sv
// ----------------------------------------------------------------------------
// cspm_mac: shared multiply-accumulate unit
// Registers the control word alongside the memory read, multiplies sample by
// weight, then accumulates with two's-complement wrap and strobes the result.
// ----------------------------------------------------------------------------
module cspm_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cspm_pkg::mac_ctrl_t             ctrl_i,
  input  logic [cspm_pkg::DATA_BITS-1:0]  sample_i,
  input  logic [cspm_pkg::DATA_BITS-1:0]  weight_i,
  output logic                            done_o,
  output logic [cspm_pkg::DATA_BITS-1:0]  sum_o
);

  cspm_pkg::mac_ctrl_t                    rd_ctrl_q;
  cspm_pkg::mac_ctrl_t                    mul_ctrl_q;
  logic signed [cspm_pkg::PROD_BITS-1:0]  prod_q, prod_d;
  logic signed [cspm_pkg::ACC_BITS-1:0]   acc_q, acc_d;
  logic signed [cspm_pkg::ACC_BITS-1:0]   prod_ext;
  logic                                   done_q;

  // Padding taps contribute zero
  always_comb begin
    if (rd_ctrl_q.pad) begin
      prod_d = '0;
    end else begin
      prod_d = $signed(sample_i) * $signed(weight_i);
    end
  end

  assign prod_ext = cspm_pkg::ACC_BITS'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (mul_ctrl_q.valid) begin
      acc_d = mul_ctrl_q.first ? prod_ext : acc_q + prod_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctrl_q  <= '0;
      mul_ctrl_q <= '0;
      done_q     <= 1'b0;
    end else begin
      rd_ctrl_q  <= ctrl_i;
      mul_ctrl_q <= rd_ctrl_q.valid ? rd_ctrl_q : '0;
      done_q     <= mul_ctrl_q.valid && mul_ctrl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign done_o = done_q;
  assign sum_o  = acc_q[cspm_pkg::DATA_BITS-1:0];

endmodule

>>> design/conv3x3_same_pad_mac.sv
// ----------------------------------------------------------------------------
// conv3x3_same_pad_mac: multichannel 3x3 convolution, stride 1, zero padding
// Stores kernel weights and input-map samples on request and computes one
// output pixel per compute request with a single shared MAC.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+-------------------------------
//  request  | in        | start, busy       | kind, out_channel, in_channel,
//           |           |                   | row, col, tap_row, tap_col, value
//  result   | out       | done_o (1 cycle)  | pixel_sum
//
//  A request is taken at a clock edge with start high and busy low.
//  Weight and sample writes finish at that edge; busy stays low, so a new
//  request can follow in the next cycle. Out-of-range writes and kind 3 drop.
//  A compute request holds busy while it walks the taps in turn on the
//  shared memory read port and MAC, and through the read, multiply
//  and accumulate stages; the next request is taken once busy drops.
//  The result shows for one cycle with done_o, in the last busy cycle;
//  the receiver cannot stall it. Out-of-range compute drops.
//  Reset clears control state only; both memories are undefined until written.
// ----------------------------------------------------------------------------
module conv3x3_same_pad_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [cspm_pkg::KIND_W-1:0]        kind_i,
  input  logic [cspm_pkg::OC_W-1:0]          out_channel_i,
  input  logic [cspm_pkg::IC_W-1:0]          in_channel_i,
  input  logic [cspm_pkg::ROW_W-1:0]         row_i,
  input  logic [cspm_pkg::COL_W-1:0]         col_i,
  input  logic [cspm_pkg::TAP_W-1:0]         tap_row_i,
  input  logic [cspm_pkg::TAP_W-1:0]         tap_col_i,
  input  logic signed [cspm_pkg::VAL_W-1:0]  value_i,
  output logic                               done_o,
  output logic signed [cspm_pkg::DATA_BITS-1:0] pixel_sum_o
);

  logic                              accept;
  logic                              weight_we, sample_we, pixel_go;
  logic [cspm_pkg::KERN_AW-1:0]      kern_waddr, kern_base;
  logic [cspm_pkg::FMAP_AW-1:0]      fmap_waddr;
  logic [cspm_pkg::DATA_BITS-1:0]    wdata;
  logic [cspm_pkg::FMAP_AW-1:0]      fmap_raddr;
  logic [cspm_pkg::KERN_AW-1:0]      kern_raddr;
  logic [cspm_pkg::DATA_BITS-1:0]    sample_rd, weight_rd;
  logic [cspm_pkg::DATA_BITS-1:0]    sum;
  logic                              seq_busy;
  logic                              mac_done;
  cspm_pkg::mac_ctrl_t               ctrl;

  assign accept = start && !seq_busy;

  // Decode the request; drop anything out of range
  assign weight_we = accept && (kind_i == cspm_pkg::KIND_WEIGHT)
                     && (32'(out_channel_i) < cspm_pkg::OUT_CH)
                     && (32'(in_channel_i) < cspm_pkg::IN_CH)
                     && (tap_row_i <= cspm_pkg::TAP_LAST)
                     && (tap_col_i <= cspm_pkg::TAP_LAST);
  assign sample_we = accept && (kind_i == cspm_pkg::KIND_SAMPLE)
                     && (32'(in_channel_i) < cspm_pkg::IN_CH)
                     && (32'(row_i) < cspm_pkg::IMG_H)
                     && (32'(col_i) < cspm_pkg::IMG_W);
  assign pixel_go  = accept && (kind_i == cspm_pkg::KIND_PIXEL)
                     && (32'(out_channel_i) < cspm_pkg::OUT_CH)
                     && (32'(row_i) < cspm_pkg::IMG_H)
                     && (32'(col_i) < cspm_pkg::IMG_W);

  // Keep the sample or weight as a DATA_BITS two's-complement value
  assign wdata = cspm_pkg::DATA_BITS'(value_i);

  assign kern_waddr = cspm_pkg::KERN_AW'(((32'(out_channel_i) * cspm_pkg::IN_CH
                                          + 32'(in_channel_i)) * 3 + 32'(tap_row_i)) * 3
                                         + 32'(tap_col_i));
  assign fmap_waddr = cspm_pkg::FMAP_AW'(32'(in_channel_i) * cspm_pkg::PLANE
                                         + 32'(row_i) * cspm_pkg::IMG_W + 32'(col_i));
  assign kern_base  = cspm_pkg::KERN_AW'(32'(out_channel_i) * cspm_pkg::IN_CH
                                         * cspm_pkg::TAPS);

  cspm_ram #(
    .DEPTH (cspm_pkg::FMAP_DEPTH),
    .WIDTH (cspm_pkg::DATA_BITS)
  ) u_fmap (
    .clk_i   (clk_i),
    .we_i    (sample_we),
    .waddr_i (fmap_waddr),
    .wdata_i (wdata),
    .re_i    (ctrl.valid),
    .raddr_i (fmap_raddr),
    .rdata_o (sample_rd)
  );

  cspm_ram #(
    .DEPTH (cspm_pkg::KERN_DEPTH),
    .WIDTH (cspm_pkg::DATA_BITS)
  ) u_kern (
    .clk_i   (clk_i),
    .we_i    (weight_we),
    .waddr_i (kern_waddr),
    .wdata_i (wdata),
    .re_i    (ctrl.valid),
    .raddr_i (kern_raddr),
    .rdata_o (weight_rd)
  );

  // Walk the taps of one output pixel
  cspm_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (pixel_go),
    .row_i   (row_i),
    .col_i   (col_i),
    .kbase_i (kern_base),
    .done_i  (mac_done),
    .busy_o  (seq_busy),
    .faddr_o (fmap_raddr),
    .kaddr_o (kern_raddr),
    .ctrl_o  (ctrl)
  );

  // Multiply and accumulate each tap, strobe the sum after the last one
  cspm_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (sample_rd),
    .weight_i (weight_rd),
    .done_o   (mac_done),
    .sum_o    (sum)
  );

  assign busy        = seq_busy;
  assign done_o      = mac_done;
  assign pixel_sum_o = sum;

endmodule

>>> bench/conv3x3_same_pad_mac_tb.sv
// ----------------------------------------------------------------------------
// conv3x3_same_pad_mac_tb: self-checking bench for the 3x3 convolution block
// Walks a short table of directed requests, then a long stream of random
// requests, some malformed. Each compute request is predicted from a
// local copy of the weight and sample stores and checked against done_o.
// ----------------------------------------------------------------------------
module conv3x3_same_pad_mac_tb;
  import cspm_pkg::*;

  // Kind code outside the defined set; the block must drop it
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  localparam int ITEM_TARGET = 950;
  localparam int MIN_PIXELS  = 60;
  localparam int DRAIN_WAIT  = 3 * (IN_CH * TAPS + 4);
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [OC_W-1:0]          oc;
    logic [IC_W-1:0]          ic;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic [TAP_W-1:0]         trow;
    logic [TAP_W-1:0]         tcol;
    logic signed [VAL_W-1:0]  value;
  } request_t;

  // One directed row: the request and, where obvious, its typed-in result
  typedef struct packed {
    request_t                     rq;
    logic                         typed;
    logic signed [DATA_BITS-1:0]  want;
  } dir_row_t;

  localparam int DIR_ROWS = 22;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic [KIND_W-1:0]              kind_i;
  logic [OC_W-1:0]                out_channel_i;
  logic [IC_W-1:0]                in_channel_i;
  logic [ROW_W-1:0]               row_i;
  logic [COL_W-1:0]               col_i;
  logic [TAP_W-1:0]               tap_row_i;
  logic [TAP_W-1:0]               tap_col_i;
  logic signed [VAL_W-1:0]        value_i;
  logic                           done_o;
  logic signed [DATA_BITS-1:0]    pixel_sum_o;

  // Local image of the block's two stores, with written flags so that no
  // compute ever touches an entry that was never written
  logic signed [DATA_BITS-1:0] weight_mem [KERN_DEPTH];
  logic signed [DATA_BITS-1:0] sample_mem [FMAP_DEPTH];
  bit                          weight_set [KERN_DEPTH];
  bit                          sample_set [FMAP_DEPTH];

  logic signed [DATA_BITS-1:0] pixel_q [$];

  dir_row_t dir_tab [DIR_ROWS];

  int  cycle_count  = 0;
  int  mismatches   = 0;
  int  results_seen = 0;
  int  live_items   = 0;
  int  dropped      = 0;
  int  writes_done  = 0;
  int  pixels_sent  = 0;
  int  hot_base     = 0;
  bit  idle_on      = 1'b1;

  conv3x3_same_pad_mac dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .out_channel_i (out_channel_i),
    .in_channel_i  (in_channel_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .tap_row_i     (tap_row_i),
    .tap_col_i     (tap_col_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .pixel_sum_o   (pixel_sum_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count, pixel_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int weight_index(int oc, int ic, int kr, int kc);
    return ((oc * IN_CH + ic) * 3 + kr) * 3 + kc;
  endfunction

  function automatic int sample_index(int ic, int r, int c);
    return (ic * IMG_H + r) * IMG_W + c;
  endfunction

  // Sum window times weight over all input channels and taps; pad outside
  // the image with zero, wrap at ACC_BITS and keep the low DATA_BITS bits
  function automatic logic signed [DATA_BITS-1:0] conv_pixel(int oc, int r, int c);
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [DATA_BITS-1:0] s;
    logic signed [DATA_BITS-1:0] w;
    int pr;
    int pc;
    acc = '0;
    for (int ch = 0; ch < IN_CH; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr = r + i - 1;
          pc = c + j - 1;
          w  = weight_mem[weight_index(oc, ch, i, j)];
          s  = '0;
          if (pr >= 0 && pr < IMG_H && pc >= 0 && pc < IMG_W)
            s = sample_mem[sample_index(ch, pr, pc)];
          acc = acc + ACC_BITS'(longint'(s) * longint'(w));
        end
      end
    end
    return acc[DATA_BITS-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(0, 19))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return -16'sd1;
      3:       return 16'sd1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Bias coordinates to the borders and to a small hot region
  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0, 1:    return 0;
      2, 3:    return IMG_H - 1;
      4:       return $urandom_range(0, IMG_H - 1);
      default: return hot_base + $urandom_range(0, 5);
    endcase
  endfunction

  function automatic dir_row_t row_of(logic [KIND_W-1:0] kind, int oc, int ic, int r, int c,
                                      int tr, int tc, int val, bit typed, int want);
    dir_row_t d;
    d.rq    = '{kind, OC_W'(oc), IC_W'(ic), ROW_W'(r), COL_W'(c), TAP_W'(tr), TAP_W'(tc),
                VAL_W'(val)};
    d.typed = typed;
    d.want  = DATA_BITS'(want);
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [DATA_BITS-1:0] got,
                                 input logic signed [DATA_BITS-1:0] want);
    mismatches++;
    $display("[cycle %0d] mismatch: %s: got %0d, want %0d", cycle_count, what, got, want);
  endtask

  // Present one request at the falling edge, hold it until taken, then
  // update the local stores and queue the expected pixel. Entered and left
  // at a falling edge.
  task automatic issue_request(input request_t rq, input bit typed,
                               input logic signed [DATA_BITS-1:0] want);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        start         <= 1'b0;
        kind_i        <= KIND_W'($urandom);
        out_channel_i <= OC_W'($urandom);
        in_channel_i  <= IC_W'($urandom);
        row_i         <= ROW_W'($urandom);
        col_i         <= COL_W'($urandom);
        tap_row_i     <= TAP_W'($urandom);
        tap_col_i     <= TAP_W'($urandom);
        value_i       <= VAL_W'($urandom);
        @(negedge clk_i);
      end
    end
    start         <= 1'b1;
    kind_i        <= rq.kind;
    out_channel_i <= rq.oc;
    in_channel_i  <= rq.ic;
    row_i         <= rq.row;
    col_i         <= rq.col;
    tap_row_i     <= rq.trow;
    tap_col_i     <= rq.tcol;
    value_i       <= rq.value;
    do @(posedge clk_i); while (busy);

    case (rq.kind)
      KIND_WEIGHT: begin
        if (rq.oc < OUT_CH && rq.ic < IN_CH && rq.trow <= TAP_LAST && rq.tcol <= TAP_LAST) begin
          weight_mem[weight_index(rq.oc, rq.ic, rq.trow, rq.tcol)] = DATA_BITS'(rq.value);
          weight_set[weight_index(rq.oc, rq.ic, rq.trow, rq.tcol)] = 1'b1;
          writes_done++;
          live_items++;
        end else begin
          dropped++;
        end
      end
      KIND_SAMPLE: begin
        if (rq.ic < IN_CH && rq.row < IMG_H && rq.col < IMG_W) begin
          sample_mem[sample_index(rq.ic, rq.row, rq.col)] = DATA_BITS'(rq.value);
          sample_set[sample_index(rq.ic, rq.row, rq.col)] = 1'b1;
          writes_done++;
          live_items++;
        end else begin
          dropped++;
        end
      end
      KIND_PIXEL: begin
        if (rq.oc < OUT_CH && rq.row < IMG_H && rq.col < IMG_W) begin
          pixel_q.push_back(typed ? want : conv_pixel(rq.oc, rq.row, rq.col));
          pixels_sent++;
          live_items++;
        end else begin
          dropped++;
        end
      end
      default: dropped++;
    endcase
    @(negedge clk_i);
  endtask

  // Write every weight and in-image sample that pixel (oc, r, c) reads and
  // that has not been written yet; zero_fill keeps directed sums obvious
  task automatic fill_window(input int oc, input int r, input int c, input bit zero_fill);
    request_t rq;
    int pr;
    int pc;
    for (int ch = 0; ch < IN_CH; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (!weight_set[weight_index(oc, ch, i, j)]) begin
            rq       = '{KIND_WEIGHT, OC_W'(oc), IC_W'(ch), ROW_W'($urandom), COL_W'($urandom),
                         TAP_W'(i), TAP_W'(j), VAL_W'(0)};
            rq.value = zero_fill ? '0 : random_value();
            issue_request(rq, 1'b0, '0);
          end
          pr = r + i - 1;
          pc = c + j - 1;
          if (pr >= 0 && pr < IMG_H && pc >= 0 && pc < IMG_W &&
              !sample_set[sample_index(ch, pr, pc)]) begin
            rq       = '{KIND_SAMPLE, OC_W'($urandom), IC_W'(ch), ROW_W'(pr), COL_W'(pc),
                         TAP_W'($urandom), TAP_W'($urandom), VAL_W'(0)};
            rq.value = zero_fill ? '0 : random_value();
            issue_request(rq, 1'b0, '0);
          end
        end
      end
    end
  endtask

  // Take each result in the cycle done_o marks it and compare it with the
  // oldest pending pixel
  always @(posedge clk_i) begin : check_results
    logic signed [DATA_BITS-1:0] want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      results_seen++;
      if (pixel_q.size() == 0) begin
        report_mismatch("result with no pending request", pixel_sum_o, '0);
      end else begin
        want = pixel_q.pop_front();
        if (pixel_sum_o !== want)
          report_mismatch("pixel_sum", pixel_sum_o, want);
      end
    end
  end

  initial begin
    request_t rq;
    int pick;
    int oc;
    int r;
    int c;

    // Directed table. Fill writes ahead of each compute store zeros, so the
    // typed sums read straight off the rows above them.
    // Center tap, small values
    dir_tab[0]  = row_of(KIND_WEIGHT, 0, 0, 0, 0, 1, 1, 3, 0, 0);
    dir_tab[1]  = row_of(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 5, 0, 0);
    dir_tab[2]  = row_of(KIND_PIXEL,  0, 0, 0, 0, 0, 0, 0, 1, 15);
    // Most negative squared: 2^30 wraps to zero in 16 bits
    dir_tab[3]  = row_of(KIND_WEIGHT, 0, 0, 0, 0, 1, 1, -32768, 0, 0);
    dir_tab[4]  = row_of(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, -32768, 0, 0);
    dir_tab[5]  = row_of(KIND_PIXEL,  0, 0, 0, 0, 0, 0, 0, 1, 0);
    // Most positive squared: low bits are one
    dir_tab[6]  = row_of(KIND_WEIGHT, 0, 0, 0, 0, 1, 1, 32767, 0, 0);
    dir_tab[7]  = row_of(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 32767, 0, 0);
    dir_tab[8]  = row_of(KIND_PIXEL,  0, 0, 0, 0, 0, 0, 0, 1, 1);
    // Mixed extremes
    dir_tab[9]  = row_of(KIND_WEIGHT, 0, 0, 0, 0, 1, 1, -32768, 0, 0);
    dir_tab[10] = row_of(KIND_PIXEL,  0, 0, 0, 0, 0, 0, 0, 1, -32768);
    // Weight writes with a tap beyond the kernel and an unknown kind drop
    dir_tab[11] = row_of(KIND_WEIGHT, 0, 0, 0, 0, 3, 1, 99, 0, 0);
    dir_tab[12] = row_of(KIND_WEIGHT, 0, 0, 0, 0, 1, 3, 77, 0, 0);
    dir_tab[13] = row_of(KIND_NONE,   7, 3, 31, 31, 3, 3, -1, 0, 0);
    dir_tab[14] = row_of(KIND_PIXEL,  0, 0, 0, 0, 0, 0, 0, 1, -32768);
    // Far corner: the padded tap's weight must not count
    dir_tab[15] = row_of(KIND_WEIGHT, 7, 3, 0, 0, 2, 2, 32767, 0, 0);
    dir_tab[16] = row_of(KIND_WEIGHT, 7, 3, 0, 0, 0, 0, 2, 0, 0);
    dir_tab[17] = row_of(KIND_SAMPLE, 0, 3, 30, 30, 0, 0, -7, 0, 0);
    dir_tab[18] = row_of(KIND_PIXEL,  7, 0, 31, 31, 0, 0, 0, 1, -14);
    // Last sample of the map, then a wrapping sum left to the predictor
    dir_tab[19] = row_of(KIND_SAMPLE, 0, 3, 31, 31, 3, 3, 32767, 0, 0);
    dir_tab[20] = row_of(KIND_WEIGHT, 7, 3, 0, 0, 1, 1, -1, 0, 0);
    dir_tab[21] = row_of(KIND_PIXEL,  7, 0, 31, 31, 0, 0, 0, 0, 0);

    rst_ni        <= 1'b0;
    start         <= 1'b0;
    kind_i        <= '0;
    out_channel_i <= '0;
    in_channel_i  <= '0;
    row_i         <= '0;
    col_i         <= '0;
    tap_row_i     <= '0;
    tap_col_i     <= '0;
    value_i       <= '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].rq.kind == KIND_PIXEL)
        fill_window(dir_tab[k].rq.oc, dir_tab[k].rq.row, dir_tab[k].rq.col, 1'b1);
      issue_request(dir_tab[k].rq, dir_tab[k].typed, dir_tab[k].want);
    end

    // Random part: compute requests preceded by the writes they
    // need, mixed with overwrites, dropped writes and unknown kinds
    hot_base = $urandom_range(0, IMG_H - 6);
    while (live_items < ITEM_TARGET || pixels_sent < MIN_PIXELS) begin
      // Drop idling for the last stretch of the run
      idle_on = (live_items < ITEM_TARGET * 85 / 100);
      pick = $urandom_range(0, 99);
      rq   = '{KIND_W'($urandom), OC_W'($urandom), IC_W'($urandom), ROW_W'($urandom),
               COL_W'($urandom), TAP_W'($urandom), TAP_W'($urandom), VAL_W'($urandom)};
      rq.value = random_value();
      if (pick < 45) begin
        oc = $urandom_range(0, OUT_CH - 1);
        r  = pick_coord();
        c  = pick_coord();
        fill_window(oc, r, c, 1'b0);
        rq.kind = KIND_PIXEL;
        rq.oc   = OC_W'(oc);
        rq.row  = ROW_W'(r);
        rq.col  = COL_W'(c);
      end else if (pick < 65) begin
        rq.kind = KIND_WEIGHT;
        rq.trow = TAP_W'($urandom_range(0, 2));
        rq.tcol = TAP_W'($urandom_range(0, 2));
      end else if (pick < 80) begin
        rq.kind = KIND_SAMPLE;
        rq.row  = ROW_W'(pick_coord());
        rq.col  = COL_W'(pick_coord());
      end else if (pick < 90) begin
        // Weight write with a tap beyond the kernel
        rq.kind = KIND_WEIGHT;
        if ($urandom_range(0, 1) == 0)
          rq.trow = TAP_W'(3);
        else
          rq.tcol = TAP_W'(3);
      end else if (pick < 95) begin
        rq.kind = KIND_NONE;
      end else begin
        rq.kind = KIND_SAMPLE;
      end
      issue_request(rq, 1'b0, '0);
    end
    start <= 1'b0;

    // Drain: wait for every pending pixel, then a little longer to catch
    // stray strobes
    while (pixel_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Run covered %0d stored writes, %0d dropped requests and %0d pixel computes",
             writes_done, dropped, pixels_sent);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
